@@ hw/rtl/lzw_pkg.sv @@
// Shared types, sizes and helpers for the LZW encoder.
// Depends on nothing; every other RTL file uses it by scoped names.
`default_nettype none
package lzw_pkg;

  localparam int CODE_WIDTH = 8;
  localparam int FIRST_CODE = 48;
  localparam int DICT_DEPTH = (1 << CODE_WIDTH) - FIRST_CODE;
  localparam int IDX_W      = $clog2(DICT_DEPTH);
  localparam int CNT_W      = $clog2(DICT_DEPTH + 1);

  localparam logic CMD_SCAN   = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;

  typedef logic [CODE_WIDTH-1:0] code_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // One dictionary entry: prefix code (zero for a single byte) and last byte.
  typedef struct packed {
    code_t      prefix;
    logic [7:0] data_byte;
  } dict_entry_t;

  // Outcome of one pass over the dictionary.
  typedef struct packed {
    logic single_hit;
    idx_t single_idx;
    logic ext_hit;
    idx_t ext_idx;
  } search_res_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] code;
    logic       unknown_byte;
    logic       end_of_message;
  } result_t;

  function automatic code_t idx_to_code(idx_t idx);
    return code_t'(idx) + code_t'(FIRST_CODE);
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/lzw_dict_ram.sv @@
// Dictionary store: one write port, one read port, registered read data.
// Depends on lzw_pkg.
`default_nettype none
module lzw_dict_ram (
  input  wire                 clk,
  input  wire                 we_i,
  input  lzw_pkg::idx_t       waddr_i,
  input  lzw_pkg::dict_entry_t wdata_i,
  input  wire                 re_i,
  input  lzw_pkg::idx_t       raddr_i,
  output lzw_pkg::dict_entry_t rdata_o
);

  lzw_pkg::dict_entry_t mem [lzw_pkg::DICT_DEPTH];
  lzw_pkg::dict_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_r <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_r;

endmodule
`default_nettype wire

@@ hw/rtl/lzw_search.sv @@
// Linear dictionary search: one entry read and compared per cycle, looking
// for the single-byte entry and the extended string at once. Depends on lzw_pkg.
`default_nettype none
module lzw_search (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start_i,
  input  lzw_pkg::cnt_t        used_i,
  input  wire [7:0]            key_byte_i,
  input  lzw_pkg::code_t       key_prefix_i,
  input  wire                  key_pv_i,
  output logic                 rd_en_o,
  output lzw_pkg::idx_t        rd_addr_o,
  input  lzw_pkg::dict_entry_t rd_data_i,
  output logic                 done_o,
  output lzw_pkg::search_res_t res_o
);

  logic                 busy_r, busy_nxt;
  lzw_pkg::idx_t        addr_r, addr_nxt;
  logic                 chk_r, chk_nxt;
  logic                 chk_last_r, chk_last_nxt;
  lzw_pkg::idx_t        chk_idx_r, chk_idx_nxt;
  logic                 done_r, done_nxt;
  lzw_pkg::search_res_t res_r, res_nxt;
  logic                 last;
  logic                 byte_eq;

  assign last    = (lzw_pkg::cnt_t'(addr_r) == used_i - lzw_pkg::cnt_t'(1));
  assign byte_eq = (rd_data_i.data_byte == key_byte_i);

  always_comb begin
    busy_nxt     = busy_r;
    addr_nxt     = addr_r;
    chk_nxt      = 1'b0;
    chk_last_nxt = 1'b0;
    chk_idx_nxt  = chk_idx_r;
    done_nxt     = 1'b0;
    res_nxt      = res_r;
    if (start_i) begin
      res_nxt  = '0;
      addr_nxt = '0;
      busy_nxt = (used_i != '0);
      done_nxt = (used_i == '0);
    end else if (busy_r) begin
      chk_nxt      = 1'b1;
      chk_idx_nxt  = addr_r;
      chk_last_nxt = last;
      addr_nxt     = addr_r + lzw_pkg::idx_t'(1);
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
    // compare the entry read in the previous cycle
    if (chk_r) begin
      if (byte_eq && rd_data_i.prefix == '0) begin
        res_nxt.single_hit = 1'b1;
        res_nxt.single_idx = chk_idx_r;
      end
      if (byte_eq && key_pv_i && rd_data_i.prefix == key_prefix_i) begin
        res_nxt.ext_hit = 1'b1;
        res_nxt.ext_idx = chk_idx_r;
      end
      done_nxt = chk_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      chk_r      <= 1'b0;
      chk_last_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      chk_r      <= chk_nxt;
      chk_last_r <= chk_last_nxt;
      done_r     <= done_nxt;
    end
    addr_r    <= addr_nxt;
    chk_idx_r <= chk_idx_nxt;
    res_r     <= res_nxt;
  end

  assign rd_en_o   = busy_r;
  assign rd_addr_o = addr_r;
  assign done_o    = done_r;
  assign res_o     = res_r;

endmodule
`default_nettype wire

@@ hw/rtl/lzw_out_fifo.sv @@
// Two-entry result queue; takes up to two results per cycle, gives one per cycle unless out_stall holds it.
// Depends on lzw_pkg.
`default_nettype none
module lzw_out_fifo (
  input  wire              clk,
  input  wire              rst_n,
  input  wire [1:0]        push_cnt_i,
  input  lzw_pkg::result_t push0_i,
  input  lzw_pkg::result_t push1_i,
  output logic [1:0]       free_o,
  output logic             out_valid,
  input  wire              out_stall,
  output lzw_pkg::result_t head_o
);

  lzw_pkg::result_t mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             pop;

  assign out_valid = (count_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign head_o    = mem_r[rd_ptr_r];
  assign free_o    = 2'd2 - count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_cnt_i[0];
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + push_cnt_i - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push_cnt_i != 2'd0) begin
      mem_r[wr_ptr_r] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_r[~wr_ptr_r] <= push1_i;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/lzw_encoder.sv @@
// LZW encoder top level: item register, control sequencer, dictionary RAM,
// search unit and result queue. Depends on lzw_pkg and all lzw_* modules.
//
// Usage: feed the message twice on the input channel (valid/stall). First
// every byte with in_command = scan, which builds the alphabet from the
// distinct bytes in order of first appearance (codes from 48). Then every
// byte with in_command = encode, the last one with in_final_byte set.
// Scan transactions give no result. Each encode transaction gives zero, one
// or two result transactions on the output channel (code, unknown_byte,
// end_of_message). The final byte flushes any held prefix code, flags its
// last result end_of_message and empties the dictionary for the next message.
//
// The input stalls from acceptance until the item is committed, so a new
// byte is taken only once the last one is through. The linear search
// reads one RAM entry per cycle over the dictionary entries in use (up to 208).
//
// Reset: synchronous, active low; empties the dictionary (fill count only,
// the RAM itself is not cleared) and the result queue.
// Output stall: results wait in a two-entry queue; the next input is
// accepted while results wait, but an item's results are committed only
// once the queue has room for all of them, so input stalls on a full queue.
`default_nettype none
module lzw_encoder (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        in_command,
  input  wire [7:0]  in_data_byte,
  input  wire        in_final_byte,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_code,
  output logic       out_unknown_byte,
  output logic       out_end_of_message
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;

  // held input transaction
  logic       cmd_r;
  logic [7:0] byte_r;
  logic       final_r;

  // encoder state
  lzw_pkg::code_t prefix_r, prefix_nxt;
  logic           pv_r, pv_nxt;
  lzw_pkg::cnt_t  used_r, used_nxt;

  logic accept;

  // RAM and search wiring
  logic                 we;
  lzw_pkg::dict_entry_t wdata;
  logic                 rd_en;
  lzw_pkg::idx_t        rd_addr;
  lzw_pkg::dict_entry_t rd_data;
  logic                 srch_done;
  lzw_pkg::search_res_t srch_res;

  // result queue wiring
  logic [1:0]       push_cnt;
  logic [1:0]       need;
  lzw_pkg::result_t res0, res1, head;
  logic [1:0]       free;
  logic             commit;
  logic             add_req;
  logic             clear_dict;
  lzw_pkg::code_t   single_code;
  lzw_pkg::code_t   prefix_upd;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  assign single_code = lzw_pkg::idx_to_code(srch_res.single_idx);

  // Decide the outcome of the held item from the search result.
  always_comb begin
    need       = 2'd0;
    res0       = '0;
    res1       = '0;
    add_req    = 1'b0;
    wdata      = '0;
    clear_dict = 1'b0;
    prefix_upd = prefix_r;
    pv_nxt     = pv_r;
    unique case (cmd_r)
      lzw_pkg::CMD_SCAN: begin
        // add a byte not seen before as a single-byte entry
        add_req         = !srch_res.single_hit;
        wdata.prefix    = '0;
        wdata.data_byte = byte_r;
      end
      lzw_pkg::CMD_ENCODE: begin
        if (!srch_res.single_hit) begin
          // unknown byte: flush the prefix, then the error result; drop prefix
          if (pv_r) begin
            res0.code = 8'(prefix_r);
            res1.unknown_byte   = 1'b1;
            res1.end_of_message = final_r;
            need = 2'd2;
          end else begin
            res0.unknown_byte   = 1'b1;
            res0.end_of_message = final_r;
            need = 2'd1;
          end
          prefix_upd = '0;
          pv_nxt     = 1'b0;
          clear_dict = final_r;
        end else begin
          if (!pv_r) begin
            prefix_upd = single_code;
            pv_nxt     = 1'b1;
          end else if (srch_res.ext_hit) begin
            prefix_upd = lzw_pkg::idx_to_code(srch_res.ext_idx);
          end else begin
            // emit the prefix, add prefix + byte, restart from the byte
            res0.code       = 8'(prefix_r);
            need            = 2'd1;
            add_req         = 1'b1;
            wdata.prefix    = prefix_r;
            wdata.data_byte = byte_r;
            prefix_upd      = single_code;
          end
          if (final_r) begin
            if (need == 2'd0) begin
              res0.code           = 8'(prefix_upd);
              res0.end_of_message = 1'b1;
            end else begin
              res1.code           = 8'(prefix_upd);
              res1.end_of_message = 1'b1;
            end
            need       = need + 2'd1;
            clear_dict = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign commit   = (state_r == ST_FIN) && (need <= free);
  assign push_cnt = commit ? need : 2'd0;
  // stop adding once the code space is used up
  assign we       = commit && add_req && (used_r != lzw_pkg::cnt_t'(lzw_pkg::DICT_DEPTH));

  always_comb begin
    state_nxt  = state_r;
    prefix_nxt = prefix_r;
    used_nxt   = used_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (srch_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (commit) begin
          state_nxt  = ST_IDLE;
          prefix_nxt = prefix_upd;
          if (we) begin
            used_nxt = used_r + lzw_pkg::cnt_t'(1);
          end
          if (clear_dict) begin
            used_nxt   = '0;
            prefix_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      prefix_r <= '0;
      pv_r     <= 1'b0;
      used_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      prefix_r <= prefix_nxt;
      used_r   <= used_nxt;
      if (commit) begin
        pv_r <= pv_nxt && !clear_dict;
      end
    end
    if (accept) begin
      cmd_r   <= in_command;
      byte_r  <= in_data_byte;
      final_r <= in_final_byte;
    end
  end

  lzw_dict_ram u_ram (
    .clk     (clk),
    .we_i    (we),
    .waddr_i (used_r[lzw_pkg::IDX_W-1:0]),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  lzw_search u_search (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_i      (accept),
    .used_i       (used_r),
    .key_byte_i   (byte_r),
    .key_prefix_i (prefix_r),
    .key_pv_i     (pv_r),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .done_o       (srch_done),
    .res_o        (srch_res)
  );

  lzw_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt_i (push_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .free_o     (free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .head_o     (head)
  );

  assign out_code           = head.code;
  assign out_unknown_byte   = head.unknown_byte;
  assign out_end_of_message = head.end_of_message;

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for lzw_encoder: directed and random messages fed
// through the valid/stall channels, results checked against a local predictor.
// Depends on lzw_pkg (command codes, code and result types) and the RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] octet_t;

  localparam int ITEM_TARGET    = 950;
  localparam int WATCHDOG_LIMIT = 5000;  // idle cycles before the watchdog ends the run
  localparam int TAIL_CYCLES    = 300;

  // Expected-code ledger: tracks the dictionary the encoder should hold and
  // queues the code transactions each accepted byte must produce.
  class lzw_expected_codes;
    lzw_pkg::code_t   entry_prefix[lzw_pkg::DICT_DEPTH];
    octet_t           entry_byte[lzw_pkg::DICT_DEPTH];
    int               next_code;
    lzw_pkg::code_t   held_prefix;
    bit               holding;
    lzw_pkg::result_t code_queue[$];
    int               errors;

    function new();
      next_code   = lzw_pkg::FIRST_CODE;
      held_prefix = '0;
      holding     = 1'b0;
      errors      = 0;
    endfunction

    // Code of (prefix, byte) or zero; prefix zero means a single byte.
    function lzw_pkg::code_t find_code(lzw_pkg::code_t pfx, octet_t b);
      int used;
      int i;
      used = next_code - lzw_pkg::FIRST_CODE;
      if (used > lzw_pkg::DICT_DEPTH) used = lzw_pkg::DICT_DEPTH;
      for (i = 0; i < used; i++) begin
        if (entry_prefix[i] == pfx && entry_byte[i] == b) begin
          return lzw_pkg::code_t'(lzw_pkg::FIRST_CODE + i);
        end
      end
      return '0;
    endfunction

    // Add an entry unless the code space is used up.
    function void add_entry(lzw_pkg::code_t pfx, octet_t b);
      if (next_code < lzw_pkg::FIRST_CODE + lzw_pkg::DICT_DEPTH) begin
        entry_prefix[next_code - lzw_pkg::FIRST_CODE] = pfx;
        entry_byte[next_code - lzw_pkg::FIRST_CODE]   = b;
        next_code++;
      end
    endfunction

    function void push_code(lzw_pkg::code_t c, logic unk, logic eom);
      lzw_pkg::result_t r;
      r.code           = c;
      r.unknown_byte   = unk;
      r.end_of_message = eom;
      code_queue.push_back(r);
    endfunction

    function void forget_message();
      next_code   = lzw_pkg::FIRST_CODE;
      held_prefix = '0;
      holding     = 1'b0;
    endfunction

    // Note one accepted input transaction and queue what it must emit.
    function void note_byte(logic cmd, octet_t b, logic fin);
      lzw_pkg::code_t single;
      lzw_pkg::code_t ext;
      if (cmd == lzw_pkg::CMD_SCAN) begin
        if (find_code('0, b) == '0) add_entry('0, b);
        return;
      end
      single = find_code('0, b);
      if (single == '0) begin
        // flush the held prefix, then the error transaction; drop the prefix
        if (holding) push_code(held_prefix, 1'b0, 1'b0);
        push_code('0, 1'b1, fin);
        held_prefix = '0;
        holding     = 1'b0;
        if (fin) forget_message();
        return;
      end
      if (!holding) begin
        held_prefix = single;
        holding     = 1'b1;
      end else begin
        ext = find_code(held_prefix, b);
        if (ext != '0) begin
          held_prefix = ext;
        end else begin
          push_code(held_prefix, 1'b0, 1'b0);
          add_entry(held_prefix, b);
          held_prefix = single;
        end
      end
      if (fin) begin
        push_code(held_prefix, 1'b0, 1'b1);
        forget_message();
      end
    endfunction

    function void flag(string what, int want, int got);
      errors++;
      $display("t=%0t mismatch %s: expected %0d actual %0d", $time, what, want, got);
    endfunction

    // Check one accepted result transaction against the oldest expectation.
    function void check_code(octet_t code, logic unk, logic eom);
      lzw_pkg::result_t want;
      if (code_queue.size() == 0) begin
        errors++;
        $display("t=%0t unexpected result: expected none actual code %0d unk %0b eom %0b",
                 $time, code, unk, eom);
        return;
      end
      want = code_queue.pop_front();
      if (want.code !== code) flag("code", want.code, code);
      if (want.unknown_byte !== unk) flag("unknown_byte", want.unknown_byte, unk);
      if (want.end_of_message !== eom) flag("end_of_message", want.end_of_message, eom);
    endfunction

    function int pending();
      return code_queue.size();
    endfunction
  endclass

  // All inputs start at known values; reset is held low from time zero.
  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_command    = lzw_pkg::CMD_SCAN;
  octet_t     in_data_byte  = '0;
  logic       in_final_byte = 1'b0;
  logic       out_stall     = 1'b0;
  logic       in_stall;
  logic       out_valid;
  octet_t     out_code;
  logic       out_unknown_byte;
  logic       out_end_of_message;

  lzw_expected_codes ledger = new();

  bit quiet       = 1'b0;  // set to run a stretch with no idling on either side
  int stall_left  = 0;
  int idle_cycles = 0;
  int items_sent  = 0;

  lzw_encoder dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_data_byte       (in_data_byte),
    .in_final_byte      (in_final_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_code           (out_code),
    .out_unknown_byte   (out_unknown_byte),
    .out_end_of_message (out_end_of_message)
  );

  always #1 clk = ~clk;

  // Hold length for a gap or a stall: mostly short, now and then long.
  function automatic int pick_hold();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 4);
  endfunction

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return pick_hold();
  endfunction

  // Receiver: stall the result channel in random bursts; hold a burst to its end.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (quiet || $urandom_range(0, 2) != 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall  <= 1'b1;
      stall_left = pick_hold() - 1;
    end
  end

  // Monitor: every accepted result transaction goes to the ledger.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      ledger.check_code(out_code, out_unknown_byte, out_end_of_message);
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("lzw_encoder regression: fail");
        $finish;
      end
    end
  end

  // Drive one input transaction. Valid stays high between back-to-back
  // transactions; it drops only for a gap, so each step sees one assignment.
  task automatic send_byte(input logic cmd, input octet_t b, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_data_byte  <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    ledger.note_byte(cmd, b, fin);
    items_sent++;
  endtask

  // Hold off the sender until every expected result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (ledger.pending() != 0);
  endtask

  // One random message: scan pass, then encode pass. A wide alphabet fills
  // the dictionary; a broken message mixes in scan bytes, unknown bytes and
  // may omit the final flag, so the next message inherits the dictionary.
  task automatic run_message(input int msg_no);
    octet_t alpha[$];
    octet_t scan_list[$];
    octet_t text[$];
    octet_t pool[256];
    octet_t t;
    int     n;
    int     len;
    int     j;
    int     k;
    int     style;
    bit     wide;
    bit     broken;
    logic   fin;
    wide  = (msg_no == 2 || msg_no == 12);
    style = wide ? 5 : $urandom_range(0, 9);
    if (style == 0) begin
      // noise: fully random fields
      repeat ($urandom_range(1, 8)) begin
        send_byte(1'($urandom_range(0, 1)), octet_t'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end
      return;
    end
    broken = (style == 1);
    if (wide) begin
      for (j = 0; j < 256; j++) pool[j] = octet_t'(j);
      for (j = 255; j > 0; j--) begin
        k       = $urandom_range(0, j);
        t       = pool[j];
        pool[j] = pool[k];
        pool[k] = t;
      end
      // first wide message overflows the code space during the scan,
      // the second fills it up during the encode pass
      n = (msg_no == 2) ? $urandom_range(209, 256) : $urandom_range(185, 207);
      for (j = 0; j < n; j++) alpha.push_back(pool[j]);
      len = $urandom_range(30, 45);
    end else begin
      n = $urandom_range(1, 6);
      for (j = 0; j < n; j++) alpha.push_back(octet_t'($urandom_range(0, 255)));
      len = $urandom_range(1, 30);
    end
    for (j = 0; j < len; j++) text.push_back(alpha[$urandom_range(0, alpha.size() - 1)]);
    scan_list = wide ? alpha : text;
    if (broken) begin
      for (j = 0; j < len; j++) begin
        if ($urandom_range(0, 7) == 0) text[j] = octet_t'($urandom_range(0, 255));
      end
    end
    foreach (scan_list[j]) begin
      send_byte(lzw_pkg::CMD_SCAN, scan_list[j], 1'($urandom_range(0, 1)));
    end
    for (j = 0; j < len; j++) begin
      if (broken && $urandom_range(0, 7) == 0) begin
        send_byte(lzw_pkg::CMD_SCAN, octet_t'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end
      fin = (j == len - 1) && !(broken && $urandom_range(0, 1) == 0);
      send_byte(lzw_pkg::CMD_ENCODE, text[j], fin);
    end
  endtask

  initial begin
    int msg_no;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: unknown final byte on an empty dictionary.
    send_byte(lzw_pkg::CMD_ENCODE, 8'h5A, 1'b1);
    // Scan with a repeated byte and a stray final flag, which must be ignored.
    send_byte(lzw_pkg::CMD_SCAN, 8'h00, 1'b0);
    send_byte(lzw_pkg::CMD_SCAN, 8'hFF, 1'b1);
    send_byte(lzw_pkg::CMD_SCAN, 8'h00, 1'b0);
    // Encode: mismatch adds an entry, a scan byte arrives mid-encode,
    // a two-byte string is matched, an unknown byte flushes the prefix.
    send_byte(lzw_pkg::CMD_ENCODE, 8'h00, 1'b0);
    send_byte(lzw_pkg::CMD_ENCODE, 8'hFF, 1'b0);
    send_byte(lzw_pkg::CMD_SCAN, 8'h41, 1'b0);
    send_byte(lzw_pkg::CMD_ENCODE, 8'h41, 1'b0);
    send_byte(lzw_pkg::CMD_ENCODE, 8'h00, 1'b0);
    send_byte(lzw_pkg::CMD_ENCODE, 8'hFF, 1'b0);
    send_byte(lzw_pkg::CMD_ENCODE, 8'h7E, 1'b0);
    send_byte(lzw_pkg::CMD_ENCODE, 8'h00, 1'b1);
    drain_results();
    // Single-byte message.
    send_byte(lzw_pkg::CMD_SCAN, 8'h55, 1'b0);
    send_byte(lzw_pkg::CMD_ENCODE, 8'h55, 1'b1);
    // Unknown byte as the final byte while a prefix is held.
    send_byte(lzw_pkg::CMD_SCAN, 8'h10, 1'b0);
    send_byte(lzw_pkg::CMD_ENCODE, 8'h10, 1'b0);
    send_byte(lzw_pkg::CMD_ENCODE, 8'h99, 1'b1);
    // Runs of one byte build ever longer strings of it.
    send_byte(lzw_pkg::CMD_SCAN, 8'hAA, 1'b0);
    repeat (4) send_byte(lzw_pkg::CMD_ENCODE, 8'hAA, 1'b0);
    send_byte(lzw_pkg::CMD_ENCODE, 8'hAA, 1'b1);

    // Random messages until the item budget is spent.
    msg_no = 0;
    while (items_sent < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 5) == 0);
      run_message(msg_no);
      msg_no++;
      if ($urandom_range(0, 3) == 0) drain_results();
    end
    quiet = 1'b0;

    // Wait out every expected result, then give stray results time to show.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("lzw_encoder regression: pass");
    end else begin
      $display("lzw_encoder regression: fail");
    end
    $finish;
  end

endmodule
